[src/cdpi_pkg.sv]
// Shared constants and types for the constant-divisor pseudo-inverse block.
package cdpi_pkg;

    // Fixed field widths of the input and result beats
    localparam int DIVISOR_W   = 64;
    localparam int KBITS_W     = 7;
    localparam int INVERSE_W   = 64;
    localparam int SHIFT_W     = 7;

    // Default word width of the arithmetic
    localparam int WORD_BITS_DEF = 64;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_WIDTH,
        S_DIVIDE,
        S_FINISH
    } t_state;

endpackage

[src/cdpi_if.sv]
// Valid/ready channel interfaces for the input and result beats.
interface cdpi_in_if;
    import cdpi_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [DIVISOR_W-1:0] divisor;
    logic [KBITS_W-1:0]   dividend_bits;

    modport source (output valid, output divisor, output dividend_bits, input ready);
    modport sink   (input valid, input divisor, input dividend_bits, output ready);
endinterface

interface cdpi_out_if;
    import cdpi_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [INVERSE_W-1:0] pseudo_inverse;
    logic [SHIFT_W-1:0]   shift_width;
    logic                 divisor_zero;

    modport source (output valid, output pseudo_inverse, output shift_width,
                    output divisor_zero, input ready);
    modport sink   (input valid, input pseudo_inverse, input shift_width,
                    input divisor_zero, output ready);
endinterface

[src/constant_divisor_pseudo_inverse.sv]
// Top level: shift width and pseudo-inverse of a constant divisor.
//
// For a divisor b (low WORD_BITS bits used) and a dividend bit count k
// (saturated to WORD_BITS) the block returns n, the smallest n >= 1 with
// 2^n >= b, and the low WORD_BITS bits of ceil(2^(n+k)/b). A zero divisor
// returns divisor_zero = 1 with both other fields 0. One subtractor of
// WORD_BITS+2 bits does all the work under a small sequencer: it forms b-1,
// grows the all-ones mask that sets n, and then runs a restoring division
// that yields k+1 quotient bits, one quotient bit per cycle. The block takes
// one item at a time; a finished result waits in the output register while
// the next item is accepted.
module constant_divisor_pseudo_inverse #(
    parameter int WORD_BITS = cdpi_pkg::WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cdpi_in_if.sink     i_in,
    cdpi_out_if.source  o_out
);
    import cdpi_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int CW = $clog2(WORD_BITS + 1);

    // Control state
    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;

    // Datapath registers
    logic [W-1:0]  r_b, n_b;
    logic [W-1:0]  r_bm1, n_bm1;
    logic [W-1:0]  r_ones, n_ones;
    logic [W:0]    r_rem, n_rem;
    logic [W-1:0]  r_quo, n_quo;
    logic [CW-1:0] r_n, n_n;
    logic          r_zero, n_zero;
    logic [W-1:0]  r_out_inv, n_out_inv;
    logic [CW-1:0] r_out_n, n_out_n;
    logic          r_out_zero, n_out_zero;

    // Shared subtractor
    logic [W:0]    sub_a, sub_b;
    logic [W+1:0]  sub_diff;
    logic          sub_borrow;

    // Input decode
    logic [W-1:0]  in_b;
    logic [CW-1:0] in_k;

    assign in_b = i_in.divisor[W-1:0];
    assign in_k = (i_in.dividend_bits > KBITS_W'(W)) ? CW'(W) : CW'(i_in.dividend_bits);

    // Select subtractor operands per phase
    always_comb begin
        unique case (r_state)
            S_PREP: begin
                sub_a = {1'b0, r_b};
                sub_b = (W+1)'(1);
            end
            S_WIDTH: begin
                sub_a = {1'b0, r_ones};
                sub_b = {1'b0, r_bm1};
            end
            default: begin
                sub_a = r_rem;
                sub_b = {1'b0, r_b};
            end
        endcase
    end

    assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_borrow = sub_diff[W+1];

    // Sequencer: next state and datapath updates
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_b         = r_b;
        n_bm1       = r_bm1;
        n_ones      = r_ones;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_n         = r_n;
        n_zero      = r_zero;
        n_out_inv   = r_out_inv;
        n_out_n     = r_out_n;
        n_out_zero  = r_out_zero;
        n_out_valid = r_out_valid;
        i_in.ready  = 1'b0;

        // drop the result once the sink takes it
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_b    = in_b;
                    n_cnt  = in_k;
                    n_quo  = '0;
                    n_zero = (in_b == '0);
                    n_n    = '0;
                    n_state = (in_b == '0) ? S_FINISH : S_PREP;
                end
            end
            S_PREP: begin
                // form b-1 and seed the mask search
                n_bm1   = sub_diff[W-1:0];
                n_ones  = W'(1);
                n_n     = CW'(1);
                n_state = S_WIDTH;
            end
            S_WIDTH: begin
                // grow the mask while it is below b-1
                if (sub_borrow) begin
                    n_ones = {r_ones[W-2:0], 1'b1};
                    n_n    = CW'(r_n + 1'b1);
                end else begin
                    n_rem   = {1'b0, r_ones};
                    n_state = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                // one restoring-division step, then shift in a one
                if (!sub_borrow) begin
                    n_rem = {sub_diff[W-1:0], 1'b1};
                end else begin
                    n_rem = {r_rem[W-1:0], 1'b1};
                end
                n_quo = {r_quo[W-2:0], ~sub_borrow};
                if (r_cnt == '0) begin
                    n_state = S_FINISH;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_FINISH: begin
                // load the output register when it is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_inv   = r_zero ? '0 : r_quo + 1'b1;
                    n_out_n     = r_zero ? '0 : r_n;
                    n_out_zero  = r_zero;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_b        <= n_b;
        r_bm1      <= n_bm1;
        r_ones     <= n_ones;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_n        <= n_n;
        r_zero     <= n_zero;
        r_out_inv  <= n_out_inv;
        r_out_n    <= n_out_n;
        r_out_zero <= n_out_zero;
    end

    // Result beat
    assign o_out.valid          = r_out_valid;
    assign o_out.pseudo_inverse = INVERSE_W'(r_out_inv);
    assign o_out.shift_width    = SHIFT_W'(r_out_n);
    assign o_out.divisor_zero   = r_out_zero;

endmodule

[src/cdpi_chk.sv]
// Port-level checks for the constant-divisor pseudo-inverse block.
module cdpi_chk #(
    parameter int WORD_BITS = cdpi_pkg::WORD_BITS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic [cdpi_pkg::INVERSE_W-1:0] i_pseudo_inverse,
    input logic [cdpi_pkg::SHIFT_W-1:0]   i_shift_width,
    input logic                           i_divisor_zero
);
    import cdpi_pkg::*;

    // No result directly after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A zero divisor carries zero results
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_divisor_zero) |-> (i_pseudo_inverse == '0 && i_shift_width == '0))
        else $error("zero divisor with nonzero results");

    // Shift width lies in 1..WORD_BITS for a real divisor
    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_divisor_zero) |->
            (i_shift_width != '0 && i_shift_width <= SHIFT_W'(WORD_BITS)))
        else $error("shift width out of range");

    // Busy after taking an input beat
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken again while busy");

    // A waiting result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_pseudo_inverse)))
        else $error("result dropped or changed while stalled");

endmodule

bind constant_divisor_pseudo_inverse cdpi_chk #(.WORD_BITS(WORD_BITS)) u_cdpi_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_pseudo_inverse (o_out.pseudo_inverse),
    .i_shift_width    (o_out.shift_width),
    .i_divisor_zero   (o_out.divisor_zero)
);
